[rtl/core/htq_pkg.sv]
// shared types and constants of the heightmap triangle height query block
package htq_pkg;

  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int SAMPLE_BITS_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_DEPTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN = 3'd6;

  localparam logic [8:0]  GRID_WIDTH_RST  = 9'd256;
  localparam logic [8:0]  GRID_DEPTH_RST  = 9'd256;
  localparam logic [15:0] WORLD_WIDTH_RST = 16'd255;
  localparam logic [15:0] WORLD_DEPTH_RST = 16'd255;
  localparam logic [23:0] SCALE_X_RST     = 24'h010000;
  localparam logic [23:0] SCALE_Z_RST     = 24'h010000;
  localparam logic [7:0]  HEIGHT_GAIN_RST = 8'd20;

  localparam logic CMD_LOAD = 1'b0;

  // 1.0 in the 16-bit fraction format
  localparam logic [16:0] ONE_FIX = 17'h10000;

  // width of a corner address ahead of store sizing
  localparam int ADDR_W = 17;

  typedef struct packed {
    logic        command;
    logic [15:0] sample_index;
    logic [7:0]  sample_value;
    logic [15:0] query_x;
    logic [15:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic [23:0] height;
    logic        outside;
  } out_item_t;

  // triangle selection and weights that ride along with a query
  typedef struct packed {
    logic        outside;
    logic        upper;
    logic [16:0] fa;
    logic [16:0] fb;
  } tri_meta_t;

  typedef struct packed {
    logic              is_load;
    logic [ADDR_W-1:0] base;
    logic [15:0]       index;
    logic [7:0]        value;
    tri_meta_t         meta;
  } fetch_req_t;

endpackage

[rtl/core/htq_fetch.sv]
// height store with its single-port sequencer: loads, corner reads and corner assembly
module htq_fetch #(
  parameter int MAX_SAMPLES = htq_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = htq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [8:0]                    grid_width,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  htq_pkg::fetch_req_t           req,
  output logic                          set_valid,
  input  logic                          set_ready,
  output htq_pkg::tri_meta_t            set_meta,
  output logic [3:0][SAMPLE_BITS-1:0]   corner
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int XW = (AW > htq_pkg::ADDR_W) ? AW : htq_pkg::ADDR_W;
  localparam logic [1:0] FIRST_CORNER = 2'd0;
  localparam logic [1:0] LAST_CORNER  = 2'd3;

  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rdata;

  logic                          seq_busy;
  logic [1:0]                    seq_cnt;
  logic [3:0][XW-1:0]            seq_addr;
  logic [3:0]                    asm_rng;
  htq_pkg::tri_meta_t            asm_meta;
  logic [2:0][SAMPLE_BITS-1:0]   asm_p;
  logic                          pend_valid;
  logic [1:0]                    pend_corner;

  logic                          final_data;
  logic                          col_free;
  logic                          hold;
  logic                          start;
  logic                          start_read;
  logic                          start_outside;
  logic [XW-1:0]                 req_base;
  logic [XW-1:0]                 gwx;
  logic [3:0][XW-1:0]            new_addr;
  logic [3:0]                    new_rng;
  logic [XW-1:0]                 ld_addr;
  logic                          ld_rng;
  logic                          mem_we;
  logic                          mem_re;
  logic [XW-1:0]                 addr_x;
  logic                          addr_rng;
  logic [AW-1:0]                 mem_idx;
  logic [SAMPLE_BITS-1:0]        cap;

  always_comb begin
    final_data    = pend_valid && (pend_corner == LAST_CORNER);
    col_free      = !set_valid || set_ready;
    // last corner waiting on a full collector freezes the port
    hold          = final_data && !col_free;
    req_ready     = !hold && !seq_busy;
    start         = req_valid && req_ready;
    start_read    = start && !req.is_load && !req.meta.outside;
    start_outside = start && !req.is_load && req.meta.outside;

    req_base    = XW'(req.base);
    gwx         = XW'(grid_width);
    new_addr[0] = req_base;
    new_addr[1] = req_base + gwx;
    new_addr[2] = req_base + XW'(1);
    new_addr[3] = req_base + gwx + XW'(1);
    for (int i = 0; i < 4; i++) begin
      new_rng[i] = {1'b0, new_addr[i]} < (XW+1)'(MAX_SAMPLES);
    end
    ld_addr = XW'(req.index);
    ld_rng  = {1'b0, ld_addr} < (XW+1)'(MAX_SAMPLES);

    mem_we = start && req.is_load && ld_rng;
    mem_re = seq_busy || start_read;

    if (seq_busy) begin
      addr_x   = seq_addr[seq_cnt];
      addr_rng = asm_rng[seq_cnt];
    end else if (req.is_load) begin
      addr_x   = ld_addr;
      addr_rng = ld_rng;
    end else begin
      addr_x   = new_addr[0];
      addr_rng = new_rng[0];
    end
    // out-of-store corners read entry 0 and are masked on capture
    mem_idx = addr_rng ? addr_x[AW-1:0] : '0;

    cap = asm_rng[pend_corner] ? rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= SAMPLE_BITS'(req.value);
    end else if (mem_re) begin
      rdata <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_busy    <= 1'b0;
      seq_cnt     <= FIRST_CORNER;
      pend_valid  <= 1'b0;
      pend_corner <= FIRST_CORNER;
      set_valid   <= 1'b0;
    end else begin
      if (!hold) begin
        pend_valid  <= mem_re || start_outside;
        pend_corner <= seq_busy ? seq_cnt : (start_outside ? LAST_CORNER : FIRST_CORNER);
      end
      if (start_read) begin
        seq_busy <= 1'b1;
        seq_cnt  <= FIRST_CORNER + 2'd1;
      end else if (seq_busy) begin
        seq_cnt <= seq_cnt + 2'd1;
        if (seq_cnt == LAST_CORNER) begin
          seq_busy <= 1'b0;
        end
      end
      if (final_data && col_free) begin
        set_valid <= 1'b1;
      end else if (set_ready) begin
        set_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !req.is_load) begin
      seq_addr <= new_addr;
      asm_meta <= req.meta;
      asm_rng  <= req.meta.outside ? 4'b0000 : new_rng;
    end
    if (pend_valid && !hold && (pend_corner != LAST_CORNER)) begin
      asm_p[pend_corner] <= cap;
    end
    if (final_data && col_free) begin
      corner   <= {cap, asm_p[2], asm_p[1], asm_p[0]};
      set_meta <= asm_meta;
    end
  end

  a_hold_idle_seq: assert property (@(posedge clk) disable iff (rst)
    hold |-> !seq_busy)
    else $error("collector stall while corner reads are still issuing");

  a_port_single: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store port written and read in one cycle");

  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    pend_valid && (pend_corner != LAST_CORNER) |=>
      pend_valid && (pend_corner == $past(pend_corner) + 2'd1))
    else $error("corner reads not back to back");

  a_set_held: assert property (@(posedge clk) disable iff (rst)
    set_valid && !set_ready |=> set_valid && $stable(corner) && $stable(set_meta))
    else $error("stalled corner set changed");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    seq_busy |-> !req_ready)
    else $error("request taken while corner reads are in progress");

endmodule

[rtl/core/heightmap_triangle_height_query_top.sv]
// top level of the heightmap triangle height query block
//
// in channel (in_valid/in_ready/in_item) carries loads and queries in order.
// a load writes one sample of the height store and gives no result; a query
// gives one result on the out channel (out_valid/out_ready/out_item).
// configuration is a plain write port (cfg_we, cfg_index, cfg_data), written
// while the block is idle, a duty of the user that the block does not enforce;
// unknown indexes are dropped. a query inside the extent reads the single store
// port once per corner and a load writes it once; a query beyond the extent
// does not use it, and no request is taken while corner reads are in progress.
// the port is the rate limit; the front pipeline (scale multiply, cell locate,
// base address) and the back pipeline (weight multiply, sum, gain multiply)
// run alongside it.
// reset clears the pipeline and the configuration registers; the store
// itself holds whatever it held and needs no clearing pass.
// a stalled sink fills the output register and then the stages behind it;
// in_ready drops once the front pipeline is full, nothing is dropped.
module heightmap_triangle_height_query_top #(
  parameter int MAX_SAMPLES = htq_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = htq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  htq_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output htq_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [htq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [htq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = SAMPLE_BITS + 1;   // signed corner difference
  localparam int PW = SAMPLE_BITS + 19;  // difference times weight
  localparam int HW = SAMPLE_BITS + 16;  // interpolated height, 16 fraction bits
  localparam int EW = SAMPLE_BITS + 20;  // sum before clamp
  localparam int ZW = HW + 9;            // height times gain plus rounding
  localparam logic [ZW-1:0] ROUND_HALF = ZW'(128);

  logic [8:0]  grid_width;
  logic [8:0]  grid_depth;
  logic [15:0] world_width;
  logic [15:0] world_depth;
  logic [23:0] scale_x;
  logic [23:0] scale_z;
  logic [7:0]  height_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= htq_pkg::GRID_WIDTH_RST;
      grid_depth  <= htq_pkg::GRID_DEPTH_RST;
      world_width <= htq_pkg::WORLD_WIDTH_RST;
      world_depth <= htq_pkg::WORLD_DEPTH_RST;
      scale_x     <= htq_pkg::SCALE_X_RST;
      scale_z     <= htq_pkg::SCALE_Z_RST;
      height_gain <= htq_pkg::HEIGHT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        htq_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[8:0];
        htq_pkg::CFG_GRID_DEPTH:  grid_depth  <= cfg_data[8:0];
        htq_pkg::CFG_WORLD_WIDTH: world_width <= cfg_data[15:0];
        htq_pkg::CFG_WORLD_DEPTH: world_depth <= cfg_data[15:0];
        htq_pkg::CFG_SCALE_X:     scale_x     <= cfg_data[23:0];
        htq_pkg::CFG_SCALE_Z:     scale_z     <= cfg_data[23:0];
        htq_pkg::CFG_HEIGHT_GAIN: height_gain <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // grid size clamped to 2..256
  logic [8:0] gw;
  logic [8:0] gd;
  logic [8:0] gw_m1;
  logic [8:0] gd_m1;
  logic [8:0] gw_m2;
  logic [8:0] gd_m2;

  always_comb begin
    gw = (grid_width < 9'd2) ? 9'd2 : ((grid_width > 9'd256) ? 9'd256 : grid_width);
    gd = (grid_depth < 9'd2) ? 9'd2 : ((grid_depth > 9'd256) ? 9'd256 : grid_depth);
    gw_m1 = gw - 9'd1;
    gd_m1 = gd - 9'd1;
    gw_m2 = gw - 9'd2;
    gd_m2 = gd - 9'd2;
  end

  // front pipeline: scale, locate, base address
  logic        a_valid;
  logic        a_load;
  logic        a_out;
  logic [15:0] a_index;
  logic [7:0]  a_value;
  logic [39:0] a_pos_x;
  logic [39:0] a_pos_z;

  logic        b_valid;
  logic        b_load;
  logic        b_out;
  logic [15:0] b_index;
  logic [7:0]  b_value;
  logic [7:0]  b_cx;
  logic [7:0]  b_cz;
  logic [16:0] b_u;
  logic [16:0] b_v;

  logic                c_valid;
  htq_pkg::fetch_req_t c_req;

  logic take_a;
  logic take_b;
  logic take_c;
  logic req_ready;

  logic [23:0] ip_x;
  logic [23:0] ip_z;
  logic        at_end_x;
  logic        at_end_z;
  logic [17:0] uv_sum;
  logic        upper;

  always_comb begin
    take_c   = !c_valid || req_ready;
    take_b   = !b_valid || take_c;
    take_a   = !a_valid || take_b;
    in_ready = take_a;

    ip_x     = a_pos_x[39:16];
    ip_z     = a_pos_z[39:16];
    // at or past the last sample: last cell, fraction 1.0
    at_end_x = ip_x >= 24'(gw_m1);
    at_end_z = ip_z >= 24'(gd_m1);

    uv_sum = 18'(b_u) + 18'(b_v);
    upper  = uv_sum > 18'(htq_pkg::ONE_FIX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (take_a) a_valid <= in_valid;
      if (take_b) b_valid <= a_valid;
      if (take_c) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_a) begin
      a_load  <= in_item.command == htq_pkg::CMD_LOAD;
      a_out   <= (in_item.query_x > world_width) || (in_item.query_z > world_depth);
      a_index <= in_item.sample_index;
      a_value <= in_item.sample_value;
      a_pos_x <= 40'(in_item.query_x) * 40'(scale_x);
      a_pos_z <= 40'(in_item.query_z) * 40'(scale_z);
    end
    if (take_b) begin
      b_load  <= a_load;
      b_out   <= a_out;
      b_index <= a_index;
      b_value <= a_value;
      b_cx    <= at_end_x ? gw_m2[7:0] : ip_x[7:0];
      b_cz    <= at_end_z ? gd_m2[7:0] : ip_z[7:0];
      b_u     <= at_end_x ? htq_pkg::ONE_FIX : {1'b0, a_pos_x[15:0]};
      b_v     <= at_end_z ? htq_pkg::ONE_FIX : {1'b0, a_pos_z[15:0]};
    end
    if (take_c) begin
      c_req.is_load      <= b_load;
      c_req.base         <= 17'(b_cz) * 17'(gw) + 17'(b_cx);
      c_req.index        <= b_index;
      c_req.value        <= b_value;
      c_req.meta.outside <= b_out;
      c_req.meta.upper   <= upper;
      c_req.meta.fa      <= upper ? (htq_pkg::ONE_FIX - b_u) : b_u;
      c_req.meta.fb      <= upper ? (htq_pkg::ONE_FIX - b_v) : b_v;
    end
  end

  // store and corner sequencing
  logic                        set_valid;
  logic                        set_ready;
  htq_pkg::tri_meta_t          set_meta;
  logic [3:0][SAMPLE_BITS-1:0] corner;

  htq_fetch #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_fetch (
    .clk        (clk),
    .rst        (rst),
    .grid_width (gw),
    .req_valid  (c_valid),
    .req_ready  (req_ready),
    .req        (c_req),
    .set_valid  (set_valid),
    .set_ready  (set_ready),
    .set_meta   (set_meta),
    .corner     (corner)
  );

  // back pipeline: weighted differences, sum, gain
  logic                   d_valid;
  logic                   d_out;
  logic [SAMPLE_BITS-1:0] d_base;
  logic signed [PW-1:0]   d_pa;
  logic signed [PW-1:0]   d_pb;

  logic                   e_valid;
  logic                   e_out;
  logic [HW-1:0]          e_h;

  logic take_d;
  logic take_e;
  logic take_o;

  logic signed [SW-1:0]   diff_a;
  logic signed [SW-1:0]   diff_b;
  logic signed [EW-1:0]   h_sum;
  logic [ZW-1:0]          gain_sum;
  logic [HW:0]            scaled;

  always_comb begin
    take_o    = !out_valid || out_ready;
    take_e    = !e_valid || take_o;
    take_d    = !d_valid || take_e;
    set_ready = take_d;

    if (set_meta.upper) begin
      diff_a = $signed({1'b0, corner[1]}) - $signed({1'b0, corner[3]});
      diff_b = $signed({1'b0, corner[2]}) - $signed({1'b0, corner[3]});
    end else begin
      diff_a = $signed({1'b0, corner[2]}) - $signed({1'b0, corner[0]});
      diff_b = $signed({1'b0, corner[1]}) - $signed({1'b0, corner[0]});
    end

    h_sum = $signed({4'b0, d_base, 16'h0000}) + EW'(d_pa) + EW'(d_pb);

    gain_sum = ZW'(e_h) * ZW'(height_gain) + ROUND_HALF;
    scaled   = gain_sum[ZW-1:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_d) d_valid   <= set_valid;
      if (take_e) e_valid   <= d_valid;
      if (take_o) out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_d) begin
      d_out  <= set_meta.outside;
      d_base <= set_meta.upper ? corner[3] : corner[0];
      d_pa   <= diff_a * $signed({1'b0, set_meta.fa});
      d_pb   <= diff_b * $signed({1'b0, set_meta.fb});
    end
    if (take_e) begin
      e_out <= d_out;
      e_h   <= h_sum[EW-1] ? '0 : h_sum[HW-1:0];
    end
    if (take_o) begin
      out_item.outside <= e_out;
      if (e_out) begin
        out_item.height <= 24'h000000;
      end else if (|scaled[HW:24]) begin
        out_item.height <= 24'hFFFFFF;
      end else begin
        out_item.height <= scaled[23:0];
      end
    end
  end

endmodule
